// ----- sv/dual_wheel_pid_steering_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the two-wheel PID steering block
// Clocked assertion wrappers; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef DUAL_WHEEL_PID_STEERING_ASSERT_SVH
`define DUAL_WHEEL_PID_STEERING_ASSERT_SVH

`ifndef SYNTHESIS
// Checked on every rising edge outside reset.
`define DWPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checked on every rising edge, reset included.
`define DWPS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define DWPS_ASSERT(lbl, prop, msg)
`define DWPS_ASSERT_RST(lbl, prop, msg)
`endif

`endif

// ----- sv/dwps_pkg.sv -----
// ----------------------------------------------------------------------------
// dwps_pkg
// Types, register indexes and fixed-point helpers for the steering block.
// ----------------------------------------------------------------------------
`default_nettype none

package dwps_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned PROD_W    = 64;
  localparam int unsigned TERM_W    = 48;
  localparam int unsigned PSUM_W    = 50;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SETPOINT     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KP_RIGHT     = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KI_RIGHT     = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KD_RIGHT     = 8'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KP_LEFT      = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_KI_LEFT      = 8'd5;
  localparam logic [CFG_IDX_W-1:0] REG_KD_LEFT      = 8'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ADVANCE_STEP = 8'd7;

  // Trapezoidal step: (prev + e) * 0.01 / 2 is a divide by 200, rounded
  // half away from zero. Done as (|sum| + 100) >> 3, then times
  // ceil(2^35 / 25) and >> 35, which is exact for the 30-bit operand.
  localparam logic [6:0]  TRAP_HALF  = 7'd100;
  localparam logic [30:0] TRAP_RECIP = 31'd1374389535;

  localparam logic signed [PROD_W-1:0] Q_ROUND = 64'sd32768;

  typedef struct packed {
    logic signed [DATA_W-1:0] setpoint;
    logic signed [DATA_W-1:0] kp_right;
    logic signed [DATA_W-1:0] ki_right;
    logic signed [DATA_W-1:0] kd_right;
    logic signed [DATA_W-1:0] kp_left;
    logic signed [DATA_W-1:0] ki_left;
    logic signed [DATA_W-1:0] kd_left;
    logic signed [DATA_W-1:0] advance_step;
  } cfg_t;

  // Per-tick operands handed from the state tracker to the multipliers.
  typedef struct packed {
    logic signed [DATA_W-1:0] err;
    logic signed [DATA_W-1:0] diff;
    logic signed [DATA_W-1:0] integ;
    logic signed [DATA_W-1:0] travel;
  } trk_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = DATA_W'(v);
    end
    return r;
  endfunction

  // Q32.32 product to Q32.16 (48 bits), ties toward plus infinity.
  function automatic logic signed [TERM_W-1:0] qround(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] t;
    t = p + Q_ROUND;
    return t[PROD_W-1:16];
  endfunction

endpackage

`default_nettype wire

// ----- sv/dwps_regs.sv -----
// ----------------------------------------------------------------------------
// dwps_regs
// Configuration register file; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module dwps_regs (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [dwps_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic signed [dwps_pkg::DATA_W-1:0]   cfg_data,
  output dwps_pkg::cfg_t                            cfg_o
);

  dwps_pkg::cfg_t cfg_r;
  dwps_pkg::cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg_o     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        dwps_pkg::REG_SETPOINT:     cfg_nxt.setpoint     = cfg_data;
        dwps_pkg::REG_KP_RIGHT:     cfg_nxt.kp_right     = cfg_data;
        dwps_pkg::REG_KI_RIGHT:     cfg_nxt.ki_right     = cfg_data;
        dwps_pkg::REG_KD_RIGHT:     cfg_nxt.kd_right     = cfg_data;
        dwps_pkg::REG_KP_LEFT:      cfg_nxt.kp_left      = cfg_data;
        dwps_pkg::REG_KI_LEFT:      cfg_nxt.ki_left      = cfg_data;
        dwps_pkg::REG_KD_LEFT:      cfg_nxt.kd_left      = cfg_data;
        dwps_pkg::REG_ADVANCE_STEP: cfg_nxt.advance_step = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- sv/dwps_state.sv -----
// ----------------------------------------------------------------------------
// dwps_state
// Error, difference, trapezoidal integral and travel accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

`include "dual_wheel_pid_steering_assert.svh"

module dwps_state (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                step_en,
  input  wire logic signed [dwps_pkg::DATA_W-1:0]  meas,
  input  wire dwps_pkg::cfg_t                      cfg,
  output dwps_pkg::trk_t                           step_o
);

  logic signed [dwps_pkg::DATA_W-1:0] integ_r, integ_nxt;
  logic signed [dwps_pkg::DATA_W-1:0] prev_err_r;
  logic signed [dwps_pkg::DATA_W-1:0] travel_r, travel_nxt;
  logic signed [dwps_pkg::DATA_W-1:0] err, diff;
  logic signed [32:0]                 pair_sum;
  logic        [32:0]                 pair_mag;
  logic        [32:0]                 rnd_mag;
  logic        [60:0]                 recip_prod;
  logic        [25:0]                 quot;
  logic signed [26:0]                 inc;

  always_comb begin
    err  = dwps_pkg::sat32(64'(cfg.setpoint) - 64'(meas));
    diff = dwps_pkg::sat32(64'(err) - 64'(prev_err_r));
    travel_nxt = dwps_pkg::sat32(64'(travel_r) + 64'(cfg.advance_step));

    // Integral step rounds the magnitude, then restores the sign.
    pair_sum   = 33'(prev_err_r) + 33'(err);
    pair_mag   = pair_sum[32] ? 33'(-pair_sum) : 33'(pair_sum);
    rnd_mag    = pair_mag + 33'(dwps_pkg::TRAP_HALF);
    recip_prod = 61'(rnd_mag[32:3]) * 61'(dwps_pkg::TRAP_RECIP);
    quot       = recip_prod[60:35];
    inc        = pair_sum[32] ? -27'(signed'({1'b0, quot})) : 27'(signed'({1'b0, quot}));
    integ_nxt  = dwps_pkg::sat32(64'(integ_r) + 64'(inc));

    step_o.err    = err;
    step_o.diff   = diff;
    step_o.integ  = integ_r;
    step_o.travel = travel_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r    <= '0;
      prev_err_r <= '0;
      travel_r   <= '0;
    end else if (step_en) begin
      integ_r    <= integ_nxt;
      prev_err_r <= err;
      travel_r   <= travel_nxt;
    end
  end

  `DWPS_ASSERT(a_state_hold, !step_en |=> $stable(integ_r) && $stable(prev_err_r) && $stable(travel_r), "state changed without a tick")
  `DWPS_ASSERT(a_prev_err, step_en |=> prev_err_r == $past(err), "previous error not taken from the tick")
  `DWPS_ASSERT(a_zero_advance, step_en && cfg.advance_step == 32'sd0 |=> $stable(travel_r), "travel moved with a zero step")

endmodule

`default_nettype wire

// ----- sv/dual_wheel_pid_steering.sv -----
// ----------------------------------------------------------------------------
// dual_wheel_pid_steering
// Two-wheel PID steering controller with trapezoidal integral, Q16.16.
// ----------------------------------------------------------------------------
// An accepted input passes through the input, product and output registers in
// turn, and out_valid rises once it reaches the output register.
// Throughput: one item per cycle while out_ready is high; input, product and
// output registers hold one item and move independently; stalls fill bubbles.
// Reset (synchronous, active low) clears gains, setpoint, integral,
// previous error, travel and all valid flags.
`default_nettype none

`include "dual_wheel_pid_steering_assert.svh"

module dual_wheel_pid_steering (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [dwps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic signed [dwps_pkg::DATA_W-1:0]  cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic signed [dwps_pkg::DATA_W-1:0]  in_measured_angle,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [dwps_pkg::DATA_W-1:0]       out_right_distance,
  output logic signed [dwps_pkg::DATA_W-1:0]       out_left_distance
);

  dwps_pkg::cfg_t cfg;
  dwps_pkg::trk_t trk;

  logic v0_r, v1_r, out_valid_r;
  logic ld1, ld2;

  logic signed [dwps_pkg::DATA_W-1:0] meas_r;
  logic signed [dwps_pkg::PROD_W-1:0] pkp_r_r, pki_r_r, pkd_r_r;
  logic signed [dwps_pkg::PROD_W-1:0] pkp_l_r, pki_l_r, pkd_l_r;
  logic signed [dwps_pkg::DATA_W-1:0] travel_r;
  logic signed [dwps_pkg::DATA_W-1:0] right_r, right_nxt;
  logic signed [dwps_pkg::DATA_W-1:0] left_r, left_nxt;

  logic signed [dwps_pkg::PSUM_W-1:0] psum_right, psum_left;
  logic signed [dwps_pkg::DATA_W-1:0] pid_right, pid_left, neg_left;

  dwps_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg)
  );

  dwps_state u_state (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (ld1),
    .meas    (meas_r),
    .cfg     (cfg),
    .step_o  (trk)
  );

  // Each stage loads when it is empty or its contents move on.
  assign ld2      = v1_r && (!out_valid_r || out_ready);
  assign ld1      = v0_r && (!v1_r || ld2);
  assign in_ready = !v0_r || ld1;

  assign out_valid          = out_valid_r;
  assign out_right_distance = right_r;
  assign out_left_distance  = left_r;

  always_comb begin
    psum_right = dwps_pkg::PSUM_W'(dwps_pkg::qround(pkp_r_r))
               + dwps_pkg::PSUM_W'(dwps_pkg::qround(pki_r_r))
               + dwps_pkg::PSUM_W'(dwps_pkg::qround(pkd_r_r));
    psum_left  = dwps_pkg::PSUM_W'(dwps_pkg::qround(pkp_l_r))
               + dwps_pkg::PSUM_W'(dwps_pkg::qround(pki_l_r))
               + dwps_pkg::PSUM_W'(dwps_pkg::qround(pkd_l_r));
    pid_right  = dwps_pkg::sat32(64'(psum_right));
    pid_left   = dwps_pkg::sat32(64'(psum_left));
    neg_left   = dwps_pkg::sat32(-64'(pid_left));
    right_nxt  = dwps_pkg::sat32(64'(pid_right) + 64'(travel_r));
    left_nxt   = dwps_pkg::sat32(64'(neg_left) + 64'(travel_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        v0_r <= 1'b1;
      end else if (ld1) begin
        v0_r <= 1'b0;
      end
      if (ld1) begin
        v1_r <= 1'b1;
      end else if (ld2) begin
        v1_r <= 1'b0;
      end
      if (ld2) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      meas_r <= in_measured_angle;
    end
    if (ld1) begin
      pkp_r_r  <= 64'(cfg.kp_right) * 64'(trk.err);
      pki_r_r  <= 64'(cfg.ki_right) * 64'(trk.integ);
      pkd_r_r  <= 64'(cfg.kd_right) * 64'(trk.diff);
      pkp_l_r  <= 64'(cfg.kp_left) * 64'(trk.err);
      pki_l_r  <= 64'(cfg.ki_left) * 64'(trk.integ);
      pkd_l_r  <= 64'(cfg.kd_left) * 64'(trk.diff);
      travel_r <= trk.travel;
    end
    if (ld2) begin
      right_r <= right_nxt;
      left_r  <= left_nxt;
    end
  end

  `DWPS_ASSERT_RST(a_reset_empty, !rst_n |=> !v0_r && !v1_r && !out_valid_r, "pipeline not empty after reset")
  `DWPS_ASSERT(a_ready_when_drained, !out_valid_r |-> in_ready, "input blocked with empty output register")
  `DWPS_ASSERT(a_stage_hold, v1_r && !ld2 |=> v1_r && $stable(travel_r), "product stage lost an item")

endmodule

`default_nettype wire
